// ===== src/kmp_pkg.sv =====
// shared constants, codes and sequencer state type for the kmp stream matcher
// no dependencies; imported by kmp_ram users and kmp_stream_matcher_top
`default_nettype none

package kmp_pkg;

	// pattern geometry
	localparam int MAX_PATTERN = 1024;
	localparam int SYMBOL_BITS = 16;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

	// port field widths
	localparam int SYM_IN_W = 16;
	localparam int CFG_W    = 11;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = REG_IDX_W'(0);
	localparam logic [CFG_W-1:0]     PATTERN_LENGTH_RST = CFG_W'(1);

	// opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_TRIM,
		S_TRIM_WAIT,
		S_PAT_RD,
		S_PAT_CMP,
		S_FAIL_WAIT
	} kmp_state_t;

endpackage

`default_nettype wire

// ===== src/kmp_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module kmp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/kmp_stream_matcher_top.sv =====
// kmp stream matcher top level: apb config, input/output channels, sequencer
// depends on kmp_pkg and kmp_ram (pattern store and failure table)
//
// channel   direction  handshake            payload
// input     in         in_valid / in_ready  opcode, pattern_index, symbol, end_of_text
// output    out        out_valid / out_ready found, matched_prefix
// config    in         apb psel / penable   paddr, pwdata, prdata (pattern_length)
//
// one item at a time; each ram has a single read port, registered
// load at index 0: result registered directly from the accepting transaction
// other load: S_PAT_RD then S_PAT_CMP, via S_FAIL_WAIT per failure link followed
// text symbol: S_TRIM, via S_TRIM_WAIT per link to get below the pattern length, then
//   as a load, per failure link on mismatch (amortized under two links per symbol)
// async reset clears control state only; rams need no clearing pass
// in_ready is low while busy or while a result waits and out_ready is low
`default_nettype none

module kmp_stream_matcher_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [kmp_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [kmp_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [kmp_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              opcode,
	input  wire logic [kmp_pkg::IDX_W-1:0]         pattern_index,
	input  wire logic [kmp_pkg::SYM_IN_W-1:0]      symbol,
	input  wire logic                              end_of_text,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   found,
	output logic      [kmp_pkg::LEN_W-1:0]         matched_prefix
);

	import kmp_pkg::*;

	// registers
	kmp_state_t             state_q, state_d;
	logic [CFG_W-1:0]       pattern_length_q;
	logic [IDX_W-1:0]       build_prefix_q;
	logic [LEN_W-1:0]       match_count_q;
	logic                   found_flag_q;
	logic [LEN_W-1:0]       cur_q, cur_d;
	logic                   op_q;
	logic [IDX_W-1:0]       idx_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic                   last_q;
	logic                   out_valid_q;
	logic                   out_found_q;
	logic [LEN_W-1:0]       out_prefix_q;

	// ram ports
	logic                   pat_we, pat_re;
	logic [IDX_W-1:0]       pat_raddr;
	logic [SYMBOL_BITS-1:0] pat_rdata;
	logic                   fail_we, fail_re;
	logic [IDX_W-1:0]       fail_waddr, fail_raddr;
	logic [IDX_W-1:0]       fail_wdata;
	logic [IDX_W-1:0]       fail_rdata;

	// sequencer outputs
	logic                   accept;
	logic                   cfg_write;
	logic [LEN_W-1:0]       eff_len;
	logic                   hit;
	logic [LEN_W-1:0]       m_fin;
	logic                   found_fin;
	logic                   restart;
	logic                   load_fin;
	logic                   text_fin;
	logic                   res_valid;
	logic                   res_found;
	logic [LEN_W-1:0]       res_prefix;
	logic [IDX_W-1:0]       idx_m1;
	logic [IDX_W-1:0]       start_j;
	logic                   idx_in_range;

	// apb register access
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1:2] == REG_PATTERN_LENGTH) begin
			prdata = {{(APB_DATA_W - CFG_W){1'b0}}, pattern_length_q};
		end
	end

	// effective length: zero acts as one, clamp to the store depth
	always_comb begin
		eff_len = LEN_W'(pattern_length_q);
		if (pattern_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (LEN_W'(pattern_length_q) > LEN_W'(MAX_PATTERN)) begin
			eff_len = LEN_W'(MAX_PATTERN);
		end
	end

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// border start for a load: clamp below the index
	assign idx_m1       = pattern_index - IDX_W'(1);
	assign start_j      = (build_prefix_q < pattern_index) ? build_prefix_q : idx_m1;
	assign idx_in_range = LEN_W'(pattern_index) < LEN_W'(MAX_PATTERN);

	// compare result and candidate length
	assign hit       = (pat_rdata == sym_q);
	assign m_fin     = cur_q + LEN_W'(hit);
	assign found_fin = found_flag_q || (m_fin == eff_len);

	// next state and ram control
	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		pat_we     = 1'b0;
		pat_re     = 1'b0;
		pat_raddr  = cur_q[IDX_W-1:0];
		fail_we    = 1'b0;
		fail_waddr = idx_q;
		fail_wdata = m_fin[IDX_W-1:0];
		fail_re    = 1'b0;
		fail_raddr = IDX_W'(cur_q - LEN_W'(1));
		restart    = 1'b0;
		load_fin   = 1'b0;
		text_fin   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_LOAD) begin
						if (!idx_in_range) begin
							load_fin = 1'b1;
						end else if (pattern_index == '0) begin
							pat_we     = 1'b1;
							fail_we    = 1'b1;
							fail_waddr = '0;
							fail_wdata = '0;
							restart    = 1'b1;
							load_fin   = 1'b1;
						end else begin
							pat_we  = 1'b1;
							cur_d   = LEN_W'(start_j);
							state_d = S_PAT_RD;
						end
					end else begin
						cur_d   = match_count_q;
						state_d = S_TRIM;
					end
				end
			end
			S_TRIM: begin
				if (cur_q >= eff_len) begin
					fail_re = 1'b1;
					state_d = S_TRIM_WAIT;
				end else begin
					state_d = S_PAT_RD;
				end
			end
			S_TRIM_WAIT: begin
				cur_d   = LEN_W'(fail_rdata);
				state_d = S_TRIM;
			end
			S_PAT_RD: begin
				pat_re  = 1'b1;
				state_d = S_PAT_CMP;
			end
			S_PAT_CMP: begin
				if (cur_q != '0 && !hit) begin
					fail_re = 1'b1;
					state_d = S_FAIL_WAIT;
				end else begin
					state_d = S_IDLE;
					if (op_q == OP_LOAD) begin
						fail_we  = 1'b1;
						load_fin = 1'b1;
					end else begin
						text_fin = 1'b1;
					end
				end
			end
			S_FAIL_WAIT: begin
				cur_d   = LEN_W'(fail_rdata);
				state_d = S_PAT_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result selection
	always_comb begin
		res_valid  = load_fin || text_fin;
		res_found  = found_flag_q;
		res_prefix = match_count_q;
		if (restart) begin
			res_found  = 1'b0;
			res_prefix = '0;
		end else if (text_fin) begin
			res_found  = found_fin;
			res_prefix = m_fin;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			pattern_length_q <= PATTERN_LENGTH_RST;
			build_prefix_q   <= '0;
			match_count_q    <= '0;
			found_flag_q     <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write && paddr[APB_ADDR_W-1:2] == REG_PATTERN_LENGTH) begin
				pattern_length_q <= pwdata[CFG_W-1:0];
			end
			if (restart) begin
				build_prefix_q <= '0;
				match_count_q  <= '0;
				found_flag_q   <= 1'b0;
			end else if (load_fin && state_q == S_PAT_CMP) begin
				build_prefix_q <= m_fin[IDX_W-1:0];
			end else if (text_fin) begin
				match_count_q <= last_q ? '0 : m_fin;
				found_flag_q  <= last_q ? 1'b0 : found_fin;
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (accept) begin
			op_q   <= opcode;
			idx_q  <= pattern_index;
			sym_q  <= symbol[SYMBOL_BITS-1:0];
			last_q <= end_of_text;
		end
		if (res_valid) begin
			out_found_q  <= res_found;
			out_prefix_q <= res_prefix;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = out_found_q;
	assign matched_prefix = out_prefix_q;

	// pattern store
	kmp_ram #(
		.WIDTH(SYMBOL_BITS),
		.DEPTH(MAX_PATTERN)
	) u_pattern_ram (
		.clk  (clk),
		.we   (pat_we),
		.waddr(pattern_index),
		.wdata(symbol[SYMBOL_BITS-1:0]),
		.re   (pat_re),
		.raddr(pat_raddr),
		.rdata(pat_rdata)
	);

	// failure table
	kmp_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_PATTERN)
	) u_failure_ram (
		.clk  (clk),
		.we   (fail_we),
		.waddr(fail_waddr),
		.wdata(fail_wdata),
		.re   (fail_re),
		.raddr(fail_raddr),
		.rdata(fail_rdata)
	);

	// a new result never overwrites one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || out_ready))
		else $error("result produced while output register is full");

	// no transaction is taken while a scan is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input accepted while sequencer busy");

	// a pattern restart clears the match state
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_LOAD && pattern_index == '0)
		|=> (match_count_q == '0 && !found_flag_q && build_prefix_q == '0))
		else $error("pattern restart did not clear match state");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for kmp_stream_matcher_top: directed and random pattern/text streams
// depends on kmp_pkg and the matcher rtl; predicts every result with its own kmp model

module testbench;
	import kmp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_AT_ITEM   = 150;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_BACKLOG   = 8;
	localparam int TONE_LEN       = 192;

	typedef struct packed {
		logic                opcode;
		logic [IDX_W-1:0]    index;
		logic [SYM_IN_W-1:0] sym;
		logic                last;
	} matcher_item_t;

	typedef struct packed {
		logic             found;
		logic [LEN_W-1:0] prefix;
	} match_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                opcode = OP_LOAD;
	logic [IDX_W-1:0]    pattern_index = '0;
	logic [SYM_IN_W-1:0] symbol = '0;
	logic                end_of_text = 1'b0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                found;
	logic [LEN_W-1:0]    matched_prefix;

	// pending transactions and the results they must produce
	matcher_item_t symbol_queue[$];
	match_result_t expected_matches[$];

	// kmp model state
	logic [SYM_IN_W-1:0] model_symbols [MAX_PATTERN];
	logic [IDX_W-1:0]    model_links [MAX_PATTERN];
	int unsigned         model_border = 0;
	int unsigned         model_depth = 0;
	logic                model_found = 1'b0;
	logic [CFG_W-1:0]    model_cfg_len = PATTERN_LENGTH_RST;

	int unsigned items_generated = 0;
	int unsigned items_offered = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned random_items = 0;
	int unsigned written_span = 0;
	int unsigned result_errors = 0;
	int unsigned setup_errors = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int unsigned quiet_cycles = 0;

	kmp_stream_matcher_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.pattern_index  (pattern_index),
		.symbol         (symbol),
		.end_of_text    (end_of_text),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.matched_prefix (matched_prefix)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// zero means one, anything past the store size means the whole store
	function automatic int unsigned active_length(input logic [CFG_W-1:0] value);
		if (value == 0)
			return 1;
		if (value > MAX_PATTERN)
			return MAX_PATTERN;
		return value;
	endfunction

	// advance the kmp model by one accepted transaction and queue its result
	task automatic predict_match(input logic op, input logic [IDX_W-1:0] idx,
			input logic [SYM_IN_W-1:0] sym, input logic last);
		int unsigned reach;
		int unsigned depth;
		int unsigned limit;
		match_result_t res;
		if (op == OP_LOAD) begin
			model_symbols[idx] = sym;
			if (idx == 0) begin
				// new pattern: border and any match in progress start over
				model_links[0] = '0;
				model_border = 0;
				model_depth = 0;
				model_found = 1'b0;
			end else begin
				// border in progress never reaches the index being loaded
				reach = (model_border >= idx) ? idx - 1 : model_border;
				while (reach > 0 && model_symbols[reach] != sym)
					reach = model_links[reach - 1];
				if (model_symbols[reach] == sym)
					reach++;
				model_links[idx] = IDX_W'(reach);
				model_border = reach;
			end
			res.found = model_found;
			res.prefix = LEN_W'(model_depth);
		end else begin
			limit = active_length(model_cfg_len);
			depth = model_depth;
			// continuation after a full match, or after the length shrank
			while (depth >= limit)
				depth = model_links[depth - 1];
			while (depth > 0 && model_symbols[depth] != sym)
				depth = model_links[depth - 1];
			if (model_symbols[depth] == sym)
				depth++;
			if (depth == limit)
				model_found = 1'b1;
			model_depth = depth;
			res.found = model_found;
			res.prefix = LEN_W'(model_depth);
			if (last) begin
				model_depth = 0;
				model_found = 1'b0;
			end
		end
		expected_matches.push_back(res);
	endtask

	task automatic queue_item(input logic op, input int unsigned idx,
			input logic [SYM_IN_W-1:0] sym, input logic last);
		matcher_item_t item;
		item.opcode = op;
		item.index = idx[IDX_W-1:0];
		item.sym = sym;
		item.last = last;
		symbol_queue.push_back(item);
		items_generated++;
		// loads only ever extend the written part of the store by one
		if (op == OP_LOAD && idx == written_span)
			written_span++;
	endtask

	task automatic queue_text(input logic [SYM_IN_W-1:0] sym, input logic last);
		queue_item(OP_TEXT, $urandom_range(MAX_PATTERN - 1), sym, last);
	endtask

	task automatic wait_for_results();
		do
			@(negedge clk);
		while (results_seen < items_generated);
	endtask

	task automatic check_reg(input logic [REG_IDX_W-1:0] index, input logic [CFG_W-1:0] want);
		logic [APB_DATA_W-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= {index, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got[CFG_W-1:0] !== want) begin
			$error("pattern_length readback: expected %0d, got %0d", want, got[CFG_W-1:0]);
			setup_errors++;
		end
	endtask

	// write the length register once the block is idle, then read it back
	task automatic program_length(input logic [CFG_W-1:0] value);
		wait_for_results();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_PATTERN_LENGTH, 2'b00};
		pwdata <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		model_cfg_len = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		check_reg(REG_PATTERN_LENGTH, value);
	endtask

	// one pattern over a small alphabet, then a few text sequences built from it
	task automatic run_episode();
		int unsigned start;
		int unsigned span;
		int unsigned top;
		int unsigned runs;
		int unsigned run_len;
		int unsigned pos;
		int unsigned r;
		int unsigned j;
		int unsigned k;
		logic [SYM_IN_W-1:0] letters [3];
		logic [SYM_IN_W-1:0] motif [24];
		start = items_generated;
		span = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
		for (k = 0; k < 3; k++)
			letters[k] = $urandom;
		for (k = 0; k < span; k++)
			motif[k] = letters[$urandom_range(1)];
		top = (written_span > span) ? written_span : span;
		if (top > 2047)
			top = 2047;
		r = $urandom_range(99);
		if (r < 70)
			program_length(CFG_W'(span));
		else if (r < 85)
			program_length(CFG_W'($urandom_range(top)));
		for (k = 0; k < span; k++)
			queue_item(OP_LOAD, k, motif[k], $urandom_range(1));
		// occasional reload of an earlier position
		if (span > 1 && $urandom_range(9) == 0)
			queue_item(OP_LOAD, $urandom_range(1, span - 1), letters[$urandom_range(2)], 1'b0);
		runs = $urandom_range(1, 3);
		for (j = 0; j < runs; j++) begin
			run_len = $urandom_range(4, 24);
			pos = 0;
			for (k = 0; k < run_len; k++) begin
				r = $urandom_range(99);
				if (r < 3 && k != run_len - 1) begin
					queue_item(OP_LOAD,
						$urandom_range(written_span > MAX_PATTERN - 1 ? MAX_PATTERN - 1 : written_span),
						$urandom, $urandom_range(1));
				end else if (r < 10) begin
					queue_text($urandom, k == run_len - 1);
				end else if (r < 60) begin
					queue_text(motif[pos], k == run_len - 1);
					pos = (pos + 1) % span;
				end else begin
					queue_text(letters[$urandom_range(2)], k == run_len - 1);
				end
			end
		end
		random_items += items_generated - start;
	endtask

	// input driver: one transaction at a time, held until accepted
	always @(negedge clk) begin : drive_input
		matcher_item_t head;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && items_sent != items_offered) begin
			// still waiting for in_ready
		end else if (symbol_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			head = symbol_queue.pop_front();
			opcode <= head.opcode;
			pattern_index <= head.index;
			symbol <= head.sym;
			end_of_text <= head.last;
			in_valid <= 1'b1;
			items_offered++;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// output ready: random stalls plus one long hold-off to back up the input
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && items_sent >= HOLD_AT_ITEM
				&& symbol_queue.size() >= HOLD_BACKLOG) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: predict on each input transaction, check each output transaction
	always @(posedge clk) begin : check_results
		match_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_match(opcode, pattern_index, symbol, end_of_text);
				items_sent++;
			end
			if (out_valid && out_ready) begin
				if (expected_matches.size() == 0) begin
					$error("unexpected result: found=%0d matched_prefix=%0d",
						found, matched_prefix);
					result_errors++;
				end else begin
					want = expected_matches.pop_front();
					if (found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, found);
						result_errors++;
					end
					if (matched_prefix !== want.prefix) begin
						$error("matched_prefix: expected %0d, got %0d",
							want.prefix, matched_prefix);
						result_errors++;
					end
				end
				results_seen++;
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("kmp_stream_matcher_top regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned k;
		logic [SYM_IN_W-1:0] tone;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 35;
		recv_idle_pct = 83;
		check_reg(REG_PATTERN_LENGTH, PATTERN_LENGTH_RST);

		// pattern of extreme symbols with a border, then overlapping matches
		program_length(CFG_W'(3));
		queue_item(OP_LOAD, 0, 16'h0000, 1'b0);
		queue_item(OP_LOAD, 1, 16'hFFFF, 1'b0);
		queue_item(OP_LOAD, 2, 16'h0000, 1'b0);
		queue_text(16'hFFFF, 1'b0);
		queue_text(16'h0000, 1'b0);
		queue_text(16'hFFFF, 1'b0);
		queue_text(16'h0000, 1'b0);
		queue_text(16'hFFFF, 1'b0);
		queue_text(16'h0000, 1'b1);
		queue_text(16'h1234, 1'b0);
		queue_text(16'h0000, 1'b0);
		// load mid-text with end_of_text set, then a lower index again
		queue_item(OP_LOAD, 3, 16'h0000, 1'b1);
		queue_item(OP_LOAD, 1, 16'h0000, 1'b0);
		queue_text(16'h0000, 1'b0);
		// restart while a match is in progress
		queue_item(OP_LOAD, 0, 16'hFFFF, 1'b0);
		queue_text(16'hFFFF, 1'b0);
		queue_text(16'h0000, 1'b1);
		// zero length behaves as one
		program_length('0);
		queue_text(16'hFFFF, 1'b0);
		queue_text(16'hFFFF, 1'b0);
		queue_text(16'h5A5A, 1'b1);

		while (random_items < 100)
			run_episode();
		send_idle_pct = 83;
		recv_idle_pct = 35;
		while (random_items < 200)
			run_episode();
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// long pattern of one symbol, matched all the way to the end
		program_length(CFG_W'(TONE_LEN));
		tone = $urandom;
		for (k = 0; k < TONE_LEN; k++)
			queue_item(OP_LOAD, k, tone, 1'b0);
		for (k = 0; k < TONE_LEN; k++)
			queue_text(tone, 1'b0);
		// shrink to one: the match walks the whole failure chain down
		program_length('0);
		queue_text(tone, 1'b0);
		// oversized length clamps to the store size
		program_length('1);
		queue_text(tone, 1'b0);
		queue_text(tone, 1'b0);
		queue_text(tone, 1'b1);

		while (random_items < 300)
			run_episode();

		wait_for_results();
		repeat (64) @(negedge clk);
		if (expected_matches.size() != 0) begin
			$error("%0d expected results never arrived", expected_matches.size());
			setup_errors++;
		end
		if (result_errors == 0 && setup_errors == 0)
			$display("kmp_stream_matcher_top regression: pass");
		else
			$display("kmp_stream_matcher_top regression: fail");
		$finish;
	end

endmodule
